/* hdl/polar_origin_in_triangle_test_defines.svh */
// Assertion macros shared by the polar origin-in-triangle test modules.
`ifndef POLAR_ORIGIN_IN_TRIANGLE_TEST_DEFINES_SVH
`define POLAR_ORIGIN_IN_TRIANGLE_TEST_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define PIT_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define PIT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/pit_pkg.sv */
// Shared constants, latencies and types of the polar origin-in-triangle test.
package pit_pkg;

    localparam int unsigned RAD_W   = 16;
    localparam int unsigned ANG_W   = 16;
    localparam int unsigned PHASE_W = 14;

    // Q30 fixed point constants
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    // Taylor series datapath
    localparam int unsigned TERM_W   = 32;
    localparam int unsigned SUM_W    = 35;
    localparam int unsigned N_STEPS  = 8;
    localparam int unsigned STEP_LAT = 3;

    // Pipeline latencies
    localparam int unsigned TRIG_LAT  = 2 + N_STEPS * STEP_LAT + 1;
    localparam int unsigned LANE_LAT  = TRIG_LAT + 2;
    localparam int unsigned MERGE_LAT = 4;
    localparam int unsigned TOTAL_LAT = LANE_LAT + MERGE_LAT;

    // Quadrant codes from the top two angle bits
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // Merge stage result toward the top level
    typedef struct packed {
        logic valid;
        logic in_tri;
        logic degenerate;
    } pit_result_t;

endpackage

/* hdl/polar_origin_in_triangle_test.sv */
// Top level: three polar lanes feeding the barycentric merge stage.
//
// Usage: drive the six polar fields and pulse start; a request is taken at
// every rising edge where start is high and busy is low. busy stays low, so
// a new request can enter on every cycle.
// Each request returns one result, with origin_inside and degenerate valid
// while done is high. Results come out in request order. Throughput is one
// request per cycle. Latency is set by the Taylor-series pipeline in each
// lane: 2 setup stages, 8 series steps of 3 stages each (multiply,
// reciprocal multiply, accumulate) and a round stage, then 2 stages of
// radius scaling and 4 stages of differences, cross products, sums and
// sign checks.
// The receiver cannot stall: done is a strobe and the result is gone after
// its cycle.
// Reset (rst_n low, asynchronous) clears the valid pipeline so no done strobe
// appears for requests in flight; the datapath itself holds no reset.
module polar_origin_in_triangle_test #(
    parameter int unsigned COORD_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] radius_a,
    input  logic [15:0] angle_a,
    input  logic [15:0] radius_b,
    input  logic [15:0] angle_b,
    input  logic [15:0] radius_c,
    input  logic [15:0] angle_c,
    output logic        done,
    output logic        origin_inside,
    output logic        degenerate
);

`include "polar_origin_in_triangle_test_defines.svh"

    localparam int unsigned CW = COORD_FRAC_BITS + 2;
    localparam int unsigned LL = pit_pkg::LANE_LAT;
    localparam int unsigned TL = pit_pkg::TOTAL_LAT;
    localparam int unsigned ML = pit_pkg::MERGE_LAT;

    logic                 accept;
    logic [LL-1:0]        valid_reg;
    logic                 lane_valid;
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
    pit_pkg::pit_result_t result;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Valid tracking through the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LL-2:0], accept};
    end

    assign lane_valid = valid_reg[LL-1];

    pit_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_a (
        .clk (clk), .radius (radius_a), .angle (angle_a), .x (ax), .y (ay)
    );

    pit_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_b (
        .clk (clk), .radius (radius_b), .angle (angle_b), .x (bx), .y (by)
    );

    pit_lane #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_lane_c (
        .clk (clk), .radius (radius_c), .angle (angle_c), .x (cx), .y (cy)
    );

    pit_merge #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (lane_valid),
        .ax       (ax),
        .ay       (ay),
        .bx       (bx),
        .by       (by),
        .cx       (cx),
        .cy       (cy),
        .result   (result)
    );

    assign done          = result.valid;
    assign origin_inside = result.in_tri;
    assign degenerate    = result.degenerate;

    // Checks
    `PIT_ASSERT_IMPL(a_done_has_request, done, $past(accept, TL), "stray done")
    `PIT_ASSERT_IMPL(a_degen_not_in, done && degenerate, !origin_inside, "degenerate inside")
    `PIT_ASSERT_NEXT(a_merge_valid, lane_valid, !done || $past(lane_valid, ML), "merge valid")

endmodule

/* hdl/pit_trig.sv */
// Pipelined Q30 Taylor-series sine or cosine of a quarter-turn phase.
module pit_trig #(
    parameter int unsigned COORD_FRAC_BITS = 16,
    parameter bit          IS_COS          = 1'b0
) (
    input  logic                       clk,
    input  logic [pit_pkg::PHASE_W-1:0] phase,
    output logic [COORD_FRAC_BITS:0]   mag
);

    localparam int unsigned TW     = pit_pkg::TERM_W;
    localparam int unsigned SW     = pit_pkg::SUM_W;
    localparam int unsigned NS     = pit_pkg::N_STEPS;
    localparam int unsigned RSHIFT = 30 - COORD_FRAC_BITS;

    logic [30:0]          x_reg;
    logic [TW-1:0]        term_s [0:NS];
    logic [TW-1:0]        x2_s   [0:NS];
    logic signed [SW-1:0] sum_s  [0:NS];
    logic [30:0]          clamped;
    logic [COORD_FRAC_BITS:0] mag_reg;

    // Angle in radians, then its square and the first term
    always_ff @(posedge clk)
    begin
        x_reg     <= 31'((45'(phase) * 45'(pit_pkg::HALF_PI_Q30)) >> 14);
        x2_s[0]   <= TW'((62'(x_reg) * 62'(x_reg)) >> 30);
        term_s[0] <= IS_COS ? TW'(pit_pkg::Q30_ONE) : TW'(x_reg);
        sum_s[0]  <= IS_COS ? SW'(pit_pkg::Q30_ONE) : SW'(x_reg);
    end

    // One series term per step: multiply, exact divide by constant, accumulate
    for (genvar k = 1; k <= NS; k++)
    begin : g_step
        localparam int unsigned DIV    = IS_COS ? (2*k - 1) * (2*k) : (2*k) * (2*k + 1);
        localparam int unsigned LG     = $clog2(DIV);
        localparam int unsigned SH     = TW + LG;
        localparam logic [TW:0] RECIP  =
            (TW+1)'(((65'd1 << SH) + 65'(DIV) - 65'd1) / 65'(DIV));
        localparam bit          ACTIVE = IS_COS || (k < NS);
        localparam bit          SUBTR  = (k % 2) == 1;

        logic [TW-1:0]        t_reg;
        logic [TW-1:0]        x2a_reg;
        logic signed [SW-1:0] suma_reg;
        logic [TW-1:0]        x2b_reg;
        logic signed [SW-1:0] sumb_reg;

        if (ACTIVE)
        begin : g_live
            logic [TW/2+TW:0] ph_reg;
            logic [TW/2+TW:0] pl_reg;
            logic [64:0]      full;
            logic [TW-1:0]    quo;

            assign full = (65'(ph_reg) << (TW/2)) + 65'(pl_reg);
            assign quo  = TW'(full >> SH);

            always_ff @(posedge clk)
            begin
                t_reg    <= TW'((64'(term_s[k-1]) * 64'(x2_s[k-1])) >> 30);
                x2a_reg  <= x2_s[k-1];
                suma_reg <= sum_s[k-1];
                ph_reg   <= (TW/2+TW+1)'(t_reg[TW-1:TW/2]) * (TW/2+TW+1)'(RECIP);
                pl_reg   <= (TW/2+TW+1)'(t_reg[TW/2-1:0]) * (TW/2+TW+1)'(RECIP);
                x2b_reg  <= x2a_reg;
                sumb_reg <= suma_reg;
                term_s[k] <= quo;
                x2_s[k]   <= x2b_reg;
                sum_s[k]  <= SUBTR ? sumb_reg - SW'(quo) : sumb_reg + SW'(quo);
            end
        end
        else
        begin : g_delay
            logic [TW-1:0] tb_reg;

            // sine has one term fewer: hold alignment with the cosine
            always_ff @(posedge clk)
            begin
                t_reg     <= term_s[k-1];
                x2a_reg   <= x2_s[k-1];
                suma_reg  <= sum_s[k-1];
                tb_reg    <= t_reg;
                x2b_reg   <= x2a_reg;
                sumb_reg  <= suma_reg;
                term_s[k] <= tb_reg;
                x2_s[k]   <= x2b_reg;
                sum_s[k]  <= sumb_reg;
            end
        end
    end

    // Clamp to [0, 1] in Q30
    always_comb
    begin
        if (sum_s[NS][SW-1])
            clamped = '0;
        else if (sum_s[NS] > $signed(SW'(pit_pkg::Q30_ONE)))
            clamped = pit_pkg::Q30_ONE;
        else
            clamped = 31'(sum_s[NS]);
    end

    // Round to the coordinate fraction width
    if (RSHIFT > 0)
    begin : g_round
        always_ff @(posedge clk)
        begin
            mag_reg <= (COORD_FRAC_BITS+1)'((32'(clamped) + (32'd1 << (RSHIFT - 1))) >> RSHIFT);
        end
    end
    else
    begin : g_noround
        always_ff @(posedge clk)
        begin
            mag_reg <= (COORD_FRAC_BITS+1)'(clamped);
        end
    end

    assign mag = mag_reg;

endmodule

/* hdl/pit_lane.sv */
// One lane: polar point to rounded signed Cartesian coordinates.
module pit_lane #(
    parameter int unsigned COORD_FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic [pit_pkg::RAD_W-1:0]         radius,
    input  logic [pit_pkg::ANG_W-1:0]         angle,
    output logic signed [COORD_FRAC_BITS+1:0] x,
    output logic signed [COORD_FRAC_BITS+1:0] y
);

    localparam int unsigned MW = COORD_FRAC_BITS + 1;
    localparam int unsigned CW = COORD_FRAC_BITS + 2;
    localparam int unsigned PW = pit_pkg::RAD_W + MW + 1;
    localparam int unsigned DL = pit_pkg::TRIG_LAT;

    logic [MW-1:0]               sin_mag;
    logic [MW-1:0]               cos_mag;
    logic [pit_pkg::RAD_W-1:0]   rad_d  [0:DL-1];
    pit_pkg::quad_t              quad_d [0:DL-1];
    pit_pkg::quad_t              quad;
    logic [MW-1:0]               mag_x;
    logic [MW-1:0]               mag_y;
    logic                        neg_x;
    logic                        neg_y;
    logic [MW-1:0]               mx_reg;
    logic [MW-1:0]               my_reg;
    logic                        negx_reg;
    logic                        negy_reg;
    logic signed [CW-1:0]        x_reg;
    logic signed [CW-1:0]        y_reg;

    pit_trig #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .IS_COS(1'b0)) u_sin (
        .clk   (clk),
        .phase (angle[pit_pkg::PHASE_W-1:0]),
        .mag   (sin_mag)
    );

    pit_trig #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .IS_COS(1'b1)) u_cos (
        .clk   (clk),
        .phase (angle[pit_pkg::PHASE_W-1:0]),
        .mag   (cos_mag)
    );

    // Radius and quadrant wait for the series
    always_ff @(posedge clk)
    begin
        rad_d[0]  <= radius;
        quad_d[0] <= pit_pkg::quad_t'(angle[pit_pkg::ANG_W-1:pit_pkg::PHASE_W]);
        for (int i = 1; i < DL; i++)
        begin
            rad_d[i]  <= rad_d[i-1];
            quad_d[i] <= quad_d[i-1];
        end
    end

    assign quad = quad_d[DL-1];

    // Quadrant fold: swap and pick signs
    always_comb
    begin
        case (quad)
            pit_pkg::QUAD_0:
            begin
                mag_x = cos_mag; mag_y = sin_mag; neg_x = 1'b0; neg_y = 1'b0;
            end
            pit_pkg::QUAD_1:
            begin
                mag_x = sin_mag; mag_y = cos_mag; neg_x = 1'b1; neg_y = 1'b0;
            end
            pit_pkg::QUAD_2:
            begin
                mag_x = cos_mag; mag_y = sin_mag; neg_x = 1'b1; neg_y = 1'b1;
            end
            pit_pkg::QUAD_3:
            begin
                mag_x = sin_mag; mag_y = cos_mag; neg_x = 1'b0; neg_y = 1'b1;
            end
            default:
            begin
                mag_x = cos_mag; mag_y = sin_mag; neg_x = 1'b0; neg_y = 1'b0;
            end
        endcase
    end

    // Scale by radius with round half up, sign applied afterwards
    always_ff @(posedge clk)
    begin
        mx_reg   <= MW'((PW'(rad_d[DL-1]) * PW'(mag_x) + PW'(32768)) >> 16);
        my_reg   <= MW'((PW'(rad_d[DL-1]) * PW'(mag_y) + PW'(32768)) >> 16);
        negx_reg <= neg_x;
        negy_reg <= neg_y;
        x_reg    <= negx_reg ? -$signed(CW'(mx_reg)) : $signed(CW'(mx_reg));
        y_reg    <= negy_reg ? -$signed(CW'(my_reg)) : $signed(CW'(my_reg));
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule

/* hdl/pit_merge.sv */
// Merge stage: barycentric numerators, denominator and the sign decision.
module pit_merge #(
    parameter int unsigned COORD_FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [COORD_FRAC_BITS+1:0] ax,
    input  logic signed [COORD_FRAC_BITS+1:0] ay,
    input  logic signed [COORD_FRAC_BITS+1:0] bx,
    input  logic signed [COORD_FRAC_BITS+1:0] by,
    input  logic signed [COORD_FRAC_BITS+1:0] cx,
    input  logic signed [COORD_FRAC_BITS+1:0] cy,
    output pit_pkg::pit_result_t              result
);

    localparam int unsigned DW = COORD_FRAC_BITS + 3;
    localparam int unsigned PW = 2 * DW;
    localparam int unsigned SW = PW + 1;

    logic [2:0]           valid_reg;
    logic signed [DW-1:0] d_bcy_reg, d_cbx_reg, d_acx_reg, d_acy_reg;
    logic signed [DW-1:0] d_cay_reg, d_bay_reg, d_bax_reg;
    logic signed [DW-1:0] n_cx_reg, n_cy_reg, n_ax_reg, n_ay_reg;
    logic signed [PW-1:0] p_reg [0:7];
    logic signed [SW-1:0] den_reg, n1_reg, n2_reg, n3_reg;
    logic                 den_neg;
    logic                 ok1, ok2, ok3;
    logic                 valid_out_reg;
    logic                 in_tri_reg;
    logic                 degen_reg;

    // Valid bits for the first three stages and for the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            valid_out_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= {valid_reg[1:0], in_valid};
            valid_out_reg <= valid_reg[2];
        end
    end

    // Differences and negated vertices
    always_ff @(posedge clk)
    begin
        d_bcy_reg <= DW'(by) - DW'(cy);
        d_cbx_reg <= DW'(cx) - DW'(bx);
        d_acx_reg <= DW'(ax) - DW'(cx);
        d_acy_reg <= DW'(ay) - DW'(cy);
        d_cay_reg <= DW'(cy) - DW'(ay);
        d_bay_reg <= DW'(ay) - DW'(by);
        d_bax_reg <= DW'(bx) - DW'(ax);
        n_cx_reg  <= -DW'(cx);
        n_cy_reg  <= -DW'(cy);
        n_ax_reg  <= -DW'(ax);
        n_ay_reg  <= -DW'(ay);
    end

    // Cross products
    always_ff @(posedge clk)
    begin
        p_reg[0] <= PW'(d_bcy_reg) * PW'(d_acx_reg);
        p_reg[1] <= PW'(d_cbx_reg) * PW'(d_acy_reg);
        p_reg[2] <= PW'(d_bcy_reg) * PW'(n_cx_reg);
        p_reg[3] <= PW'(d_cbx_reg) * PW'(n_cy_reg);
        p_reg[4] <= PW'(d_cay_reg) * PW'(n_cx_reg);
        p_reg[5] <= PW'(d_acx_reg) * PW'(n_cy_reg);
        p_reg[6] <= PW'(d_bay_reg) * PW'(n_ax_reg);
        p_reg[7] <= PW'(d_bax_reg) * PW'(n_ay_reg);
    end

    // Sums
    always_ff @(posedge clk)
    begin
        den_reg <= SW'(p_reg[0]) + SW'(p_reg[1]);
        n1_reg  <= SW'(p_reg[2]) + SW'(p_reg[3]);
        n2_reg  <= SW'(p_reg[4]) + SW'(p_reg[5]);
        n3_reg  <= SW'(p_reg[6]) + SW'(p_reg[7]);
    end

    // A numerator agrees when zero or of the same sign as the denominator
    assign den_neg = den_reg[SW-1];
    assign ok1 = (n1_reg == '0) || (n1_reg[SW-1] == den_neg);
    assign ok2 = (n2_reg == '0) || (n2_reg[SW-1] == den_neg);
    assign ok3 = (n3_reg == '0) || (n3_reg[SW-1] == den_neg);

    always_ff @(posedge clk)
    begin
        degen_reg  <= (den_reg == '0);
        in_tri_reg <= (den_reg != '0) && ok1 && ok2 && ok3;
    end

    assign result = '{valid: valid_out_reg, in_tri: in_tri_reg, degenerate: degen_reg};

endmodule

/* test/polar_origin_in_triangle_test_tb.sv */
// Testbench for the polar origin-in-triangle test: streams requests, checks every result.
module polar_origin_in_triangle_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAC_BITS  = 16;
    localparam int unsigned N_RANDOM   = 500;
    localparam int unsigned PAUSE_AT   = 200;
    localparam int unsigned CYCLE_CAP  = 200000;

    typedef struct {
        logic [15:0] rad_a;
        logic [15:0] ang_a;
        logic [15:0] rad_b;
        logic [15:0] ang_b;
        logic [15:0] rad_c;
        logic [15:0] ang_c;
    } tri_req_t;

    typedef struct {
        logic in_tri;
        logic degen;
    } tri_verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] radius_a = '0;
    logic [15:0] angle_a = '0;
    logic [15:0] radius_b = '0;
    logic [15:0] angle_b = '0;
    logic [15:0] radius_c = '0;
    logic [15:0] angle_c = '0;
    logic        done;
    logic        origin_inside;
    logic        degenerate;

    tri_req_t     pending_reqs[$];
    tri_verdict_t verdicts_due[$];
    bit           stim_ready = 1'b0;
    int unsigned  sent_cnt = 0;
    int unsigned  checked_cnt = 0;
    int unsigned  inside_cnt = 0;
    int unsigned  degen_cnt = 0;
    int unsigned  err_cnt = 0;
    int unsigned  cycle_cnt = 0;
    int unsigned  gap_left = 0;
    int unsigned  burst_left = 5;

    polar_origin_in_triangle_test #(.COORD_FRAC_BITS(FRAC_BITS)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .radius_a(radius_a), .angle_a(angle_a),
        .radius_b(radius_b), .angle_b(angle_b),
        .radius_c(radius_c), .angle_c(angle_c),
        .done(done), .origin_inside(origin_inside), .degenerate(degenerate)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Taylor series sine/cosine of a quarter-turn phase, Q30, clamped to [0, 1] and rounded to FRAC_BITS
    function automatic longint taylor_q30(logic [13:0] phase, bit want_cos);
        longint unsigned x, x2, term, k, n_terms;
        longint sum;
        x = (longint'(phase) * 64'd1686629713) >> 14;
        x2 = (x * x) >> 30;
        term = want_cos ? 64'd1073741824 : x;
        sum = longint'(term);
        n_terms = want_cos ? 8 : 7;
        for (k = 1; k <= n_terms; k++)
        begin
            if (want_cos)
                term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
            else
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k & 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > 64'sd1073741824)
            sum = 64'sd1073741824;
        if (FRAC_BITS < 30)
            sum = (sum + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        return sum;
    endfunction

    // Scale a signed trig value by the radius with symmetric rounding
    function automatic longint scale_coord(logic [15:0] rad, longint trig);
        longint unsigned mag;
        mag = (longint'(rad) * longint'(trig < 0 ? -trig : trig) + 64'd32768) >> 16;
        return trig < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic void polar_xy(logic [15:0] rad, logic [15:0] ang,
                                     output longint px, output longint py);
        longint s0, c0, cv, sv;
        s0 = taylor_q30(ang[13:0], 1'b0);
        c0 = taylor_q30(ang[13:0], 1'b1);
        case (pit_pkg::quad_t'(ang[15:14]))
            pit_pkg::QUAD_0: begin cv = c0;  sv = s0;  end
            pit_pkg::QUAD_1: begin cv = -s0; sv = c0;  end
            pit_pkg::QUAD_2: begin cv = -c0; sv = -s0; end
            default: begin cv = s0; sv = -c0; end
        endcase
        px = scale_coord(rad, cv);
        py = scale_coord(rad, sv);
    endfunction

    function automatic bit same_side(longint n, longint d);
        return (n == 0) || ((n < 0) == (d < 0));
    endfunction

    // Barycentric sign test of the origin against the triangle
    function automatic tri_verdict_t origin_verdict(tri_req_t r);
        longint ax, ay, bx, by, cx, cy, n1, n2, n3, den;
        tri_verdict_t v;
        polar_xy(r.rad_a, r.ang_a, ax, ay);
        polar_xy(r.rad_b, r.ang_b, bx, by);
        polar_xy(r.rad_c, r.ang_c, cx, cy);
        den = (by - cy) * (ax - cx) + (cx - bx) * (ay - cy);
        n1 = (by - cy) * (-cx) + (cx - bx) * (-cy);
        n2 = (cy - ay) * (-cx) + (ax - cx) * (-cy);
        n3 = (ay - by) * (-ax) + (bx - ax) * (-ay);
        v.degen = (den == 0);
        v.in_tri = (den != 0) && same_side(n1, den) && same_side(n2, den)
                   && same_side(n3, den);
        return v;
    endfunction

    function automatic tri_req_t mk_req(int ra, int aa, int rb, int ab, int rc, int ac);
        tri_req_t r;
        r.rad_a = 16'(ra); r.ang_a = 16'(aa);
        r.rad_b = 16'(rb); r.ang_b = 16'(ab);
        r.rad_c = 16'(rc); r.ang_c = 16'(ac);
        return r;
    endfunction

    // Driver: take accepted request, then issue the next one in bursts
    always @(posedge clk)
    begin
        tri_req_t nxt;
        bit accepted;
        accepted = rst_n && start && !busy;
        if (accepted)
        begin
            verdicts_due.push_back(origin_verdict(mk_req(radius_a, angle_a, radius_b,
                                                         angle_b, radius_c, angle_c)));
            sent_cnt++;
        end
        if (!rst_n)
            start <= 1'b0;
        else if (start && !accepted)
            start <= 1'b1;
        else if (pending_reqs.size() == 0 || gap_left != 0 ||
                 (sent_cnt == PAUSE_AT && verdicts_due.size() != 0))
        begin
            start <= 1'b0;
            if (gap_left != 0)
                gap_left--;
        end
        else
        begin
            nxt = pending_reqs.pop_front();
            radius_a <= nxt.rad_a; angle_a <= nxt.ang_a;
            radius_b <= nxt.rad_b; angle_b <= nxt.ang_b;
            radius_c <= nxt.rad_c; angle_c <= nxt.ang_c;
            start <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            else
                burst_left--;
        end
    end

    // Monitor: compare each done strobe with the oldest prediction
    always @(posedge clk)
    begin
        tri_verdict_t want;
        if (rst_n && done)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("result with no request outstanding");
                err_cnt++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                checked_cnt++;
                if (want.in_tri)
                    inside_cnt++;
                if (want.degen)
                    degen_cnt++;
                if (origin_inside !== want.in_tri)
                begin
                    $error("origin_inside: expected %0d, got %0d", want.in_tri, origin_inside);
                    err_cnt++;
                end
                if (degenerate !== want.degen)
                begin
                    $error("degenerate: expected %0d, got %0d", want.degen, degenerate);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("polar_origin_in_triangle_test_tb: FAIL");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        int unsigned n_directed, i, base, sel;
        // directed: extremes, quadrant boundaries, collinear, on-edge, on-vertex
        pending_reqs.push_back(mk_req(0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(mk_req(16'hFFFF, 16'h0000, 16'hFFFF, 16'h5555,
                                      16'hFFFF, 16'hAAAA));
        pending_reqs.push_back(mk_req(16'hFFFF, 16'h0000, 16'hFFFF, 16'h4000,
                                      16'hFFFF, 16'h8000));
        pending_reqs.push_back(mk_req(16'h8000, 16'h4000, 16'h8000, 16'h8000,
                                      16'h8000, 16'hC000));
        pending_reqs.push_back(mk_req(16'h1234, 16'h0000, 16'h1234, 16'h8000,
                                      16'h7000, 16'h4000));
        pending_reqs.push_back(mk_req(16'h4000, 16'h2000, 16'h8000, 16'h2000,
                                      16'hC000, 16'h2000));
        pending_reqs.push_back(mk_req(16'h4000, 16'h2000, 16'h8000, 16'hA000,
                                      16'hC000, 16'h2000));
        pending_reqs.push_back(mk_req(0, 16'h1234, 16'h8000, 16'h0100,
                                      16'h8000, 16'h0200));
        pending_reqs.push_back(mk_req(0, 16'h1234, 16'hFFFF, 16'h3FFF,
                                      16'hFFFF, 16'hBFFF));
        pending_reqs.push_back(mk_req(16'h5000, 16'h3FFF, 16'h5000, 16'h3FFF,
                                      16'h9000, 16'hC001));
        pending_reqs.push_back(mk_req(16'h0001, 16'h0000, 16'h0001, 16'h5555,
                                      16'h0001, 16'hAAAA));
        pending_reqs.push_back(mk_req(16'hFFFF, 16'h0100, 16'hFFFF, 16'h0200,
                                      16'hFFFF, 16'h0300));
        pending_reqs.push_back(mk_req(16'hAAAA, 16'hC000, 16'h5555, 16'h7FFF,
                                      16'hFFFF, 16'h1FFF));
        n_directed = pending_reqs.size();
        // random: uniform, small radii, opposite angles, spread angles that often enclose the origin
        for (i = 0; i < N_RANDOM; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                pending_reqs.push_back(mk_req($urandom, $urandom, $urandom,
                                              $urandom, $urandom, $urandom));
            else if (sel < 5)
                pending_reqs.push_back(mk_req($urandom_range(0, 4), $urandom,
                                              $urandom_range(0, 4), $urandom,
                                              $urandom_range(0, 4), $urandom));
            else if (sel < 6)
            begin
                base = $urandom;
                pending_reqs.push_back(mk_req($urandom, base, $urandom, base ^ 16'h8000,
                                              $urandom, $urandom));
            end
            else
            begin
                base = $urandom_range(0, 65535);
                pending_reqs.push_back(mk_req($urandom, base,
                    $urandom, (base + $urandom_range(16'h3000, 16'h7000)) & 16'hFFFF,
                    $urandom, (base + $urandom_range(16'h9000, 16'hD000)) & 16'hFFFF));
            end
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !start);
        wait (verdicts_due.size() == 0);
        repeat (pit_pkg::TOTAL_LAT + 10) @(posedge clk);
        $display("checked %0d results (%0d directed requests), %0d inside, %0d degenerate",
                 checked_cnt, n_directed, inside_cnt, degen_cnt);
        $display("random requests in bursts with gaps, one full drain mid-run");
        if (err_cnt == 0 && verdicts_due.size() == 0)
            $display("polar_origin_in_triangle_test_tb: PASS");
        else
            $display("polar_origin_in_triangle_test_tb: FAIL");
        $finish;
    end
endmodule
